// ----- rtl/htfd_pkg.sv -----
`timescale 1ns / 1ps

package htfd_pkg;

  localparam int unsigned RAW_W    = 20;
  localparam int unsigned HUM_C_W  = 14;
  localparam int unsigned TEMP_C_W = 15;
  localparam int unsigned POS_W    = 3;

  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  localparam logic [POS_W-1:0] POS_FIRST = 3'd0;
  localparam logic [POS_W-1:0] POS_HUM_HI = 3'd1;
  localparam logic [POS_W-1:0] POS_HUM_MID = 3'd2;
  localparam logic [POS_W-1:0] POS_SPLIT = 3'd3;
  localparam logic [POS_W-1:0] POS_TEMP_MID = 3'd4;
  localparam logic [POS_W-1:0] POS_TEMP_LO = 3'd5;
  localparam logic [POS_W-1:0] POS_CRC = 3'd6;

  // Full scale of the raw fields is 2^20
  localparam logic [13:0] HUM_SCALE   = 14'd10000;
  localparam logic [14:0] TEMP_SCALE  = 15'd20000;
  localparam logic [15:0] TEMP_OFFSET = 16'd5000;
  localparam logic signed [TEMP_C_W-1:0] TEMP_C_MIN = -15'sd5000;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BUSY    = 2'd1,
    ST_CRC_ERR = 2'd2
  } status_t;

  // MSB-first CRC-8 over one byte
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ----- rtl/humidity_temp_frame_decoder_unit.sv -----
`timescale 1ns / 1ps

// Decodes a seven-byte humidity/temperature measurement frame delivered one byte
// per word on the input stream. in_tuser marks byte 0 and resynchronises the count;
// after byte 6 the count wraps on its own. Bytes 0..5 run a CRC-8 (poly 0x31, init
// 0xFF) and yield the busy bit and the two 20-bit raw fields; byte 6 is the received
// CRC and produces one output word carrying status (busy before CRC error), the raw
// fields and the scaled values in hundredths. One byte is taken every clock; input
// stalls only while both the frame register and the output register hold a result
// that out_tready has not taken. Byte 6 lands in the frame register on the edge that
// takes it, and the scaling multipliers load the output register from the frame
// register once the output register is empty or out_tready takes its word.
module humidity_temp_frame_decoder_unit import htfd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic [0:0]  in_tuser,   // [0] frame_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // [13:0] humidity_centi, [28:14] temperature_centi,
                                  // [48:29] humidity_raw, [68:49] temperature_raw, rest 0
  output logic [1:0]  out_tuser   // [1:0] status
);

  // frame state
  logic [POS_W-1:0] byte_pos_r, byte_pos_nxt;
  logic [7:0]       crc_r, crc_nxt;
  logic             busy_r, busy_nxt;
  logic [RAW_W-1:0] hum_acc_r, hum_acc_nxt;
  logic [RAW_W-1:0] temp_acc_r, temp_acc_nxt;

  // completed frame, waiting for scaling
  logic             s1_valid_r, s1_valid_nxt;
  status_t          s1_status_r;
  logic [RAW_W-1:0] s1_hum_raw_r;
  logic [RAW_W-1:0] s1_temp_raw_r;

  // output register
  logic                       out_valid_r, out_valid_nxt;
  status_t                    out_status_r;
  logic [HUM_C_W-1:0]         out_hum_c_r;
  logic signed [TEMP_C_W-1:0] out_temp_c_r;
  logic [RAW_W-1:0]           out_hum_raw_r;
  logic [RAW_W-1:0]           out_temp_raw_r;

  logic             in_acc;
  logic             out_adv;
  logic [POS_W-1:0] pos;
  logic [7:0]       b;
  logic             last_byte;
  status_t          status_nxt;
  logic [33:0]      hum_prod;
  logic [34:0]      temp_prod;
  logic [15:0]      temp_c;

  assign out_adv   = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || out_adv;
  assign in_acc    = in_tvalid && in_tready;
  assign b         = in_tdata;

  always_comb begin
    if (in_tuser[0] || byte_pos_r > POS_CRC) begin
      pos = POS_FIRST;
    end else begin
      pos = byte_pos_r;
    end
  end

  assign last_byte = (pos == POS_CRC);

  always_comb begin
    byte_pos_nxt = byte_pos_r;
    crc_nxt      = crc_r;
    busy_nxt     = busy_r;
    hum_acc_nxt  = hum_acc_r;
    temp_acc_nxt = temp_acc_r;
    if (in_acc) begin
      byte_pos_nxt = last_byte ? POS_FIRST : pos + 3'd1;
      if (!last_byte) begin
        crc_nxt = crc8_byte((pos == POS_FIRST) ? CRC_INIT : crc_r, b);
      end
      case (pos)
        POS_FIRST: begin
          busy_nxt     = b[7];
          hum_acc_nxt  = '0;
          temp_acc_nxt = '0;
        end
        POS_HUM_HI:   hum_acc_nxt = {b, 12'd0};
        POS_HUM_MID:  hum_acc_nxt = hum_acc_r | {8'd0, b, 4'd0};
        POS_SPLIT: begin
          hum_acc_nxt  = hum_acc_r | {16'd0, b[7:4]};
          temp_acc_nxt = {b[3:0], 16'd0};
        end
        POS_TEMP_MID: temp_acc_nxt = temp_acc_r | {4'd0, b, 8'd0};
        POS_TEMP_LO:  temp_acc_nxt = temp_acc_r | {12'd0, b};
        default: ;
      endcase
    end
  end

  always_comb begin
    if (busy_r) begin
      status_nxt = ST_BUSY;
    end else if (crc_r != b) begin
      status_nxt = ST_CRC_ERR;
    end else begin
      status_nxt = ST_OK;
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc && last_byte) begin
      s1_valid_nxt = 1'b1;
    end else if (out_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_adv) begin
      out_valid_nxt = s1_valid_r;
    end
  end

  assign hum_prod  = 34'(s1_hum_raw_r) * 34'(HUM_SCALE);
  assign temp_prod = 35'(s1_temp_raw_r) * 35'(TEMP_SCALE);
  assign temp_c    = 16'(temp_prod[34:20]) - TEMP_OFFSET;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_pos_r  <= POS_FIRST;
      crc_r       <= CRC_INIT;
      busy_r      <= 1'b0;
      hum_acc_r   <= '0;
      temp_acc_r  <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      byte_pos_r  <= byte_pos_nxt;
      crc_r       <= crc_nxt;
      busy_r      <= busy_nxt;
      hum_acc_r   <= hum_acc_nxt;
      temp_acc_r  <= temp_acc_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && last_byte) begin
      s1_status_r   <= status_nxt;
      s1_hum_raw_r  <= hum_acc_r;
      s1_temp_raw_r <= temp_acc_r;
    end
    if (out_adv && s1_valid_r) begin
      out_status_r   <= s1_status_r;
      out_hum_c_r    <= hum_prod[33:20];
      out_temp_c_r   <= signed'(temp_c[TEMP_C_W-1:0]);
      out_hum_raw_r  <= s1_hum_raw_r;
      out_temp_raw_r <= s1_temp_raw_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {3'd0, out_temp_raw_r, out_hum_raw_r, out_temp_c_r, out_hum_c_r};

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    byte_pos_r <= POS_CRC)
    else $error("byte position out of range");

  a_start_resync: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tuser[0]) |=> byte_pos_r == POS_HUM_HI)
    else $error("start flag did not restart the byte count");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_adv) |-> !in_tready)
    else $error("pending frame could be overwritten");

  a_frame_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_adv) |=> out_valid_r)
    else $error("completed frame lost before the output register");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_status_r == ST_OK || out_status_r == ST_BUSY ||
                     out_status_r == ST_CRC_ERR))
    else $error("illegal status code on output");

  a_temp_floor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_temp_c_r >= TEMP_C_MIN)
    else $error("temperature below scale floor");

endmodule

// ----- bench/humidity_temp_frame_decoder_unit_tb.sv -----
`timescale 1ns / 1ps

module humidity_temp_frame_decoder_unit_tb;
  import htfd_pkg::*;

  localparam int unsigned WORD_TARGET = 650;
  localparam int unsigned HOLD_LEN    = 100;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned TAIL_CYCLES = 12;

  typedef struct packed {
    status_t            status;
    logic [13:0]        hum_c;
    logic signed [14:0] temp_c;
    logic [19:0]        hum_raw;
    logic [19:0]        temp_raw;
  } frame_result_t;

  typedef struct packed {
    logic [7:0]    b;
    logic          start;
    logic          fix_crc;  // replace byte with the running CRC
    logic          typed;    // expected result typed in below
    frame_result_t res;
  } plan_row_t;

  localparam frame_result_t NO_RES    = '0;
  localparam frame_result_t BUSY_ZERO = '{ST_BUSY, 14'd0, -15'sd5000, 20'h00000, 20'h00000};
  localparam frame_result_t BUSY_FULL = '{ST_BUSY, 14'd9999, 15'sd14999, 20'hFFFFF, 20'hFFFFF};

  localparam plan_row_t DIRECTED [24] = '{
    // busy bit set, all fields zero
    '{8'h80, 1'b1, 1'b0, 1'b0, NO_RES},
    '{8'h00, 1'b0, 1'b0, 1'b0, NO_RES},
    '{8'h00, 1'b0, 1'b0, 1'b0, NO_RES},
    '{8'h00, 1'b0, 1'b0, 1'b0, NO_RES},
    '{8'h00, 1'b0, 1'b0, 1'b0, NO_RES},
    '{8'h00, 1'b0, 1'b0, 1'b0, NO_RES},
    '{8'h00, 1'b0, 1'b0, 1'b1, BUSY_ZERO},
    // busy, all fields full scale
    '{8'hFF, 1'b1, 1'b0, 1'b0, NO_RES},
    '{8'hFF, 1'b0, 1'b0, 1'b0, NO_RES},
    '{8'hFF, 1'b0, 1'b0, 1'b0, NO_RES},
    '{8'hFF, 1'b0, 1'b0, 1'b0, NO_RES},
    '{8'hFF, 1'b0, 1'b0, 1'b0, NO_RES},
    '{8'hFF, 1'b0, 1'b0, 1'b0, NO_RES},
    '{8'hFF, 1'b0, 1'b0, 1'b1, BUSY_FULL},
    // no start flag after wrap, then dropped by a start mid-frame
    '{8'h00, 1'b0, 1'b0, 1'b0, NO_RES},
    '{8'hA5, 1'b0, 1'b0, 1'b0, NO_RES},
    '{8'h3C, 1'b0, 1'b0, 1'b0, NO_RES},
    // clean frame, good CRC
    '{8'h00, 1'b1, 1'b0, 1'b0, NO_RES},
    '{8'h12, 1'b0, 1'b0, 1'b0, NO_RES},
    '{8'h34, 1'b0, 1'b0, 1'b0, NO_RES},
    '{8'h56, 1'b0, 1'b0, 1'b0, NO_RES},
    '{8'h78, 1'b0, 1'b0, 1'b0, NO_RES},
    '{8'h9A, 1'b0, 1'b0, 1'b0, NO_RES},
    '{8'h00, 1'b0, 1'b1, 1'b0, NO_RES}
  };

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic [0:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;
  logic [1:0]  out_tuser;

  // decoder state as seen by the bench
  logic [2:0]  frame_pos;
  logic [7:0]  crc_acc;
  logic        busy_flag;
  logic [19:0] hum_acc;
  logic [19:0] temp_acc;

  frame_result_t pending_frames[$];
  int unsigned   error_count = 0;
  int unsigned   words_sent = 0;
  int unsigned   stall_cycles = 0;
  int unsigned   rx_stall_pct = 0;
  int unsigned   tx_gap_pct = 0;
  logic          hold_req = 1'b0;
  int unsigned   hold_count = 0;

  humidity_temp_frame_decoder_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // bitwise form: feedback is the top CRC bit xor the incoming data bit
  function automatic logic [7:0] crc8_next(input logic [7:0] c, input logic [7:0] b);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb = c[7] ^ b[i];
      c = {c[6:0], 1'b0};
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  function automatic logic [7:0] pick_byte();
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) begin
      return 8'h00;
    end else if (r == 1) begin
      return 8'hFF;
    end
    return 8'($urandom);
  endfunction

  task automatic decode_byte(input logic [7:0] b, input logic s, output logic got,
                             output frame_result_t r);
    logic [2:0]  pos;
    logic [33:0] h_prod;
    logic [34:0] t_prod;
    if (s) begin
      frame_pos = POS_FIRST;
    end
    pos = (frame_pos > POS_CRC) ? POS_FIRST : frame_pos;
    got = 1'b0;
    r   = '0;
    case (pos)
      POS_FIRST: begin
        crc_acc   = CRC_INIT;
        hum_acc   = '0;
        temp_acc  = '0;
        busy_flag = b[7];
      end
      POS_HUM_HI:   hum_acc = {b, 12'h000};
      POS_HUM_MID:  hum_acc[11:4] = b;
      POS_SPLIT: begin
        hum_acc[3:0] = b[7:4];
        temp_acc = {b[3:0], 16'h0000};
      end
      POS_TEMP_MID: temp_acc[15:8] = b;
      POS_TEMP_LO:  temp_acc[7:0] = b;
      default: ;
    endcase
    if (pos != POS_CRC) begin
      crc_acc   = crc8_next(crc_acc, b);
      frame_pos = pos + 3'd1;
    end else begin
      if (busy_flag) begin
        r.status = ST_BUSY;
      end else if (crc_acc != b) begin
        r.status = ST_CRC_ERR;
      end else begin
        r.status = ST_OK;
      end
      h_prod     = hum_acc * 34'd10000;
      t_prod     = temp_acc * 35'd20000;
      r.hum_c    = h_prod[33:20];
      r.temp_c   = 15'(t_prod[34:20] - 15'd5000);
      r.hum_raw  = hum_acc;
      r.temp_raw = temp_acc;
      got        = 1'b1;
      frame_pos  = POS_FIRST;
    end
  endtask

  task automatic flag_error(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    error_count++;
  endtask

  task automatic send_word(input logic [7:0] b, input logic s, input logic use_typed,
                           input frame_result_t typed_res);
    logic          got;
    frame_result_t r;
    while ($urandom_range(99) < tx_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= s;
    do begin
      @(posedge clk);
    end while (!in_tready);
    decode_byte(b, s, got, r);
    if (got) begin
      pending_frames.push_back(use_typed ? typed_res : r);
    end
    words_sent++;
  endtask

  task automatic send_good_frame();
    logic [7:0] fr [7];
    logic [7:0] c;
    logic       s0;
    fr[0]    = pick_byte();
    fr[0][7] = ($urandom_range(3) == 0);
    c = CRC_INIT;
    for (int i = 1; i < 6; i++) begin
      fr[i] = pick_byte();
    end
    for (int i = 0; i < 6; i++) begin
      c = crc8_next(c, fr[i]);
    end
    fr[6] = ($urandom_range(99) < 65) ? c : pick_byte();
    // lean on the wrap now and then when aligned
    s0 = !(frame_pos == POS_FIRST && $urandom_range(4) == 0);
    send_word(fr[0], s0, 1'b0, NO_RES);
    for (int i = 1; i < 7; i++) begin
      send_word(fr[i], 1'b0, 1'b0, NO_RES);
    end
  endtask

  // receiver: checks each word and drives out_tready
  always @(posedge clk) begin
    frame_result_t e;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (pending_frames.size() == 0) begin
          flag_error($sformatf("unexpected result word, status %0d", out_tuser));
        end else begin
          e = pending_frames.pop_front();
          if (out_tuser != e.status) begin
            flag_error($sformatf("status got %0d want %0d", out_tuser, e.status));
          end
          if (out_tdata[13:0] != e.hum_c) begin
            flag_error($sformatf("humidity_centi got %0d want %0d",
                                 out_tdata[13:0], e.hum_c));
          end
          if (out_tdata[28:14] != e.temp_c) begin
            flag_error($sformatf("temperature_centi got %0d want %0d",
                                 $signed(out_tdata[28:14]), e.temp_c));
          end
          if (out_tdata[48:29] != e.hum_raw) begin
            flag_error($sformatf("humidity_raw got %h want %h", out_tdata[48:29], e.hum_raw));
          end
          if (out_tdata[68:49] != e.temp_raw) begin
            flag_error($sformatf("temperature_raw got %h want %h",
                                 out_tdata[68:49], e.temp_raw));
          end
          if (out_tdata[71:69] != 3'b000) begin
            flag_error($sformatf("pad bits got %b", out_tdata[71:69]));
          end
        end
      end
      if (hold_req && hold_count < HOLD_LEN) begin
        out_tready <= 1'b0;
        hold_count <= hold_count + 1;
      end else begin
        out_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    int unsigned phase;
    int unsigned pick;
    int unsigned n;
    logic [7:0]  b;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    frame_pos = POS_FIRST;
    crc_acc   = CRC_INIT;
    busy_flag = 1'b0;
    hum_acc   = '0;
    temp_acc  = '0;
    phase     = 0;
    tx_gap_pct = 6;
    rx_stall_pct = 71;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED[i]) begin
      b = DIRECTED[i].fix_crc ? crc_acc : DIRECTED[i].b;
      send_word(b, DIRECTED[i].start, DIRECTED[i].typed, DIRECTED[i].res);
    end

    while (words_sent < WORD_TARGET) begin
      if (phase == 0 && words_sent >= 230) begin
        phase = 1;
        // drain everything before swapping the idle rates
        in_tvalid <= 1'b0;
        while (pending_frames.size() != 0) begin
          @(posedge clk);
        end
        tx_gap_pct = 71;
        rx_stall_pct <= 6;
      end else if (phase == 1 && words_sent >= 450) begin
        phase = 2;
        tx_gap_pct = 0;
        rx_stall_pct <= 0;
        hold_req <= 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 75) begin
        send_good_frame();
      end else if (pick < 90) begin
        // truncated frame, next one must resync on the start flag
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) begin
          send_word(pick_byte(), (i == 0), 1'b0, NO_RES);
        end
      end else begin
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) begin
          send_word(pick_byte(), 1'($urandom_range(1)), 1'b0, NO_RES);
        end
      end
    end
    in_tvalid <= 1'b0;

    while (pending_frames.size() != 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
